// File: src/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
// Assert that an antecedent implies a consequent in the following cycle.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// File: src/pdat_pkg.sv
package pdat_pkg;
    localparam logic [2:0] ACT_SEND = 3'd0;
    localparam logic [2:0] ACT_RECV = 3'd1;
    localparam logic [2:0] ACT_BUILD = 3'd2;
    localparam logic [2:0] ACT_ACK = 3'd3;
    localparam logic [2:0] ACT_TICK = 3'd4;

    localparam logic [2:0] KIND_SENT = 3'd0;
    localparam logic [2:0] KIND_ACCEPTED = 3'd1;
    localparam logic [2:0] KIND_STALE = 3'd2;
    localparam logic [2:0] KIND_RANGE = 3'd3;
    localparam logic [2:0] KIND_NOACK = 3'd4;
    localparam logic [2:0] KIND_DELIVERED = 3'd5;
    localparam logic [2:0] KIND_DROPPED = 3'd6;
    localparam logic [2:0] KIND_NONE = 3'd7;

    localparam logic [1:0] REG_SEND_ACKS = 2'd0;
    localparam logic [1:0] REG_PROCESS_ACKS = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    localparam int MAX_RESULTS = 32;

    // one queue entry as it moves along a cell chain
    typedef struct packed {
        logic [15:0] a;
        logic [31:0] b;
    } pdat_entry_t;

    // shift command shared by all cells of a chain
    typedef struct packed {
        logic push;
        logic pop;
        logic upd_tail;
    } pdat_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [15:0] seq_out;
        logic [15:0] range_first;
        logic [15:0] range_length;
        logic overflow;
        logic last;
    } pdat_res_t;
endpackage

// File: src/pdat_cell.sv
module pdat_cell
    import pdat_pkg::*;
(
    input  logic        clk,
    input  pdat_cmd_t   cmd,
    input  logic [6:0]  pos,
    input  logic [6:0]  fill,
    input  pdat_entry_t new_entry,
    input  pdat_entry_t right_entry,
    output pdat_entry_t entry
);
    pdat_entry_t entry_reg;
    pdat_entry_t entry_next;

    // cell pos holds entry pos of the queue, head at pos 0
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.pop)
        begin
            entry_next = right_entry;
        end
        else if (cmd.push && pos == fill)
        begin
            entry_next = new_entry;
        end
        else if (cmd.upd_tail && pos + 7'd1 == fill)
        begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule

// File: src/pdat_chain.sv
module pdat_chain
    import pdat_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic        clk,
    input  pdat_cmd_t   cmd,
    input  logic [6:0]  fill,
    input  pdat_entry_t new_entry,
    output pdat_entry_t head,
    output pdat_entry_t tail
);
    pdat_entry_t ent [DEPTH+1];

    assign ent[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        pdat_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (7'(g)),
            .fill       (fill),
            .new_entry  (new_entry),
            .right_entry(ent[g+1]),
            .entry      (ent[g])
        );
    end

    assign head = ent[0];

    // tail read: fill-1, fill at most DEPTH
    always_comb
    begin
        tail = ent[0];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (7'(i + 1) == fill)
            begin
                tail = ent[i];
            end
        end
    end
endmodule

// File: src/packet_delivery_ack_tracker.sv
// A send, receive, build or unused-code item shows its one word from res_reg, registered in ST_WORK.
// Ack-in and tick items walk the in-flight cell chain, one entry popped or skipped per cycle
// while no result word waits; each walk word is held one step so the final one carries tlast;
// up to 32 words per item. The block takes one item at a time: s_axis_tready is high only
// in ST_IDLE, and output stalls hold an item in ST_WORK or ST_OUT.
// Reset (rst_n low, async) clears counters and fills, config to 1, 1, 500; cells keep no reset.
module packet_delivery_ack_tracker
    import pdat_pkg::*;
#(
    parameter int FLIGHT_DEPTH  = 32,
    parameter int PENDING_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: rx_seq[15:0], ack_present[16], ack_first[32:17], ack_length[48:33],
    //        now_ticks[80:49], zero fill to 88 bits
    input  logic [87:0] s_axis_tdata,
    // tuser: action[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: seq_out[15:0], range_first[31:16], range_length[47:32], overflow[48],
    //        zero fill to 56 bits
    output logic [55:0] m_axis_tdata,
    // tuser: kind[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        send_acks_reg, process_acks_reg;
    logic [31:0] timeout_reg;
    logic [15:0] next_send_reg, next_expected_reg;
    logic [6:0]  ffill_reg, ffill_next;
    logic [6:0]  pfill_reg, pfill_next;

    // latched item
    logic [2:0]  act_reg;
    logic [15:0] rx_reg;
    logic        present_reg;
    logic [16:0] next_reg, next_next;
    logic [16:0] stop_reg;
    logic [31:0] now_reg;
    logic [5:0]  cnt_reg, cnt_next;

    pdat_res_t   res_reg, res_next;
    logic        res_valid_reg, res_valid_next;

    // The walk holds its newest word here until the next step shows
    // whether that word ends the walk.
    logic        hold_reg, hold_next;
    pdat_res_t   word_reg, word_next;

    pdat_cmd_t   fcmd, pcmd;
    pdat_entry_t fnew, pnew, fhead, ftail, phead, ptail;

    pdat_chain #(.DEPTH(FLIGHT_DEPTH)) u_flight
    (
        .clk(clk), .cmd(fcmd), .fill(ffill_reg),
        .new_entry(fnew), .head(fhead), .tail(ftail)
    );

    pdat_chain #(.DEPTH(PENDING_DEPTH)) u_pend
    (
        .clk(clk), .cmd(pcmd), .fill(pfill_reg),
        .new_entry(pnew), .head(phead), .tail(ptail)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    logic [16:0] tail_end;
    logic [32:0] due;
    logic        wstep;
    logic        wemit;

    always_comb
    begin
        state_next     = state_reg;
        ffill_next     = ffill_reg;
        pfill_next     = pfill_reg;
        next_next      = next_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        hold_next      = hold_reg;
        word_next      = word_reg;
        fcmd           = '0;
        pcmd           = '0;
        fnew.a         = next_send_reg;
        fnew.b         = now_reg;
        pnew.a         = rx_reg;
        pnew.b         = 32'd1;
        tail_end       = {1'b0, ptail.a} + {1'b0, ptail.b[15:0]};
        due            = {1'b0, fhead.b} + {1'b0, timeout_reg};
        wstep          = 1'b0;
        wemit          = 1'b0;
        if (out_acc)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_WORK;
                    cnt_next   = '0;
                    next_next  = {1'b0, s_axis_tdata[32:17]};
                end
            end
            ST_WORK:
            begin
                // hold while the previous result word waits
                if (!res_valid_reg || out_acc)
                begin
                    res_next       = '0;
                    res_next.kind  = KIND_NONE;
                    res_next.last  = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_OUT;
                    priority case (act_reg)
                        ACT_SEND:
                        begin
                            res_next.kind    = KIND_SENT;
                            res_next.seq_out = next_send_reg;
                            if (process_acks_reg)
                            begin
                                if (ffill_reg < 7'(FLIGHT_DEPTH))
                                begin
                                    fcmd.push  = 1'b1;
                                    ffill_next = ffill_reg + 7'd1;
                                end
                                else
                                begin
                                    res_next.overflow = 1'b1;
                                end
                            end
                        end
                        ACT_RECV:
                        begin
                            res_next.seq_out = rx_reg;
                            if (rx_reg < next_expected_reg)
                            begin
                                res_next.kind = KIND_STALE;
                            end
                            else
                            begin
                                res_next.kind = KIND_ACCEPTED;
                                if (send_acks_reg)
                                begin
                                    if (pfill_reg != 7'd0 && tail_end == {1'b0, rx_reg}
                                        && ptail.b[15:0] != 16'hFFFF)
                                    begin
                                        pcmd.upd_tail = 1'b1;
                                        pnew.a = ptail.a;
                                        pnew.b = {16'd0, ptail.b[15:0] + 16'd1};
                                    end
                                    else if (pfill_reg < 7'(PENDING_DEPTH))
                                    begin
                                        pcmd.push  = 1'b1;
                                        pfill_next = pfill_reg + 7'd1;
                                    end
                                    else
                                    begin
                                        res_next.overflow = 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_BUILD:
                        begin
                            if (pfill_reg == 7'd0)
                            begin
                                res_next.kind = KIND_NOACK;
                            end
                            else
                            begin
                                res_next.kind         = KIND_RANGE;
                                res_next.range_first  = phead.a;
                                res_next.range_length = phead.b[15:0];
                                pcmd.pop              = 1'b1;
                                pfill_next            = pfill_reg - 7'd1;
                            end
                        end
                        ACT_ACK:
                        begin
                            // one walk step per cycle while no result word waits; a skip step emits nothing
                            if (present_reg && next_reg < stop_reg && ffill_reg != 7'd0
                                && cnt_reg != 6'(MAX_RESULTS))
                            begin
                                wstep = 1'b1;
                                if ({1'b0, fhead.a} <= next_reg)
                                begin
                                    wemit             = 1'b1;
                                    word_next         = '0;
                                    word_next.kind    = ({1'b0, fhead.a} == next_reg)
                                                        ? KIND_DELIVERED : KIND_DROPPED;
                                    word_next.seq_out = fhead.a;
                                    fcmd.pop          = 1'b1;
                                    ffill_next        = ffill_reg - 7'd1;
                                    cnt_next          = cnt_reg + 6'd1;
                                    if ({1'b0, fhead.a} == next_reg)
                                    begin
                                        next_next = next_reg + 17'd1;
                                    end
                                end
                                else
                                begin
                                    next_next = ({1'b0, fhead.a} < stop_reg)
                                                ? {1'b0, fhead.a} : stop_reg;
                                end
                            end
                        end
                        ACT_TICK:
                        begin
                            if (ffill_reg != 7'd0 && cnt_reg != 6'(MAX_RESULTS)
                                && due < {1'b0, now_reg})
                            begin
                                wstep             = 1'b1;
                                wemit             = 1'b1;
                                word_next         = '0;
                                word_next.kind    = KIND_DROPPED;
                                word_next.seq_out = fhead.a;
                                fcmd.pop          = 1'b1;
                                ffill_next        = ffill_reg - 7'd1;
                                cnt_next          = cnt_reg + 6'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    // walk step: release the held word once a newer one exists
                    if ((act_reg == ACT_ACK || act_reg == ACT_TICK) && wstep)
                    begin
                        state_next = ST_WORK;
                        if (wemit && hold_reg)
                        begin
                            res_next       = word_reg;
                            res_valid_next = 1'b1;
                        end
                        else
                        begin
                            res_next       = res_reg;
                            res_valid_next = 1'b0;
                        end
                        if (wemit)
                        begin
                            hold_next = 1'b1;
                        end
                    end
                    // walk ended: send the held word as last, or a none word
                    else if ((act_reg == ACT_ACK || act_reg == ACT_TICK) && hold_reg)
                    begin
                        res_next      = word_reg;
                        res_next.last = 1'b1;
                        hold_next     = 1'b0;
                    end
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || out_acc)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            send_acks_reg     <= 1'b1;
            process_acks_reg  <= 1'b1;
            timeout_reg       <= 32'd500;
            next_send_reg     <= '0;
            next_expected_reg <= '0;
            ffill_reg         <= '0;
            pfill_reg         <= '0;
            res_valid_reg     <= 1'b0;
            cnt_reg           <= '0;
            hold_reg          <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ffill_reg     <= ffill_next;
            pfill_reg     <= pfill_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
            hold_reg      <= hold_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SEND_ACKS:    send_acks_reg    <= cfg_data[0];
                    REG_PROCESS_ACKS: process_acks_reg <= cfg_data[0];
                    REG_TIMEOUT:      timeout_reg      <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_WORK && act_reg == ACT_SEND && state_next == ST_OUT)
            begin
                next_send_reg <= next_send_reg + 16'd1;
            end
            if (state_reg == ST_WORK && act_reg == ACT_RECV && state_next == ST_OUT
                && rx_reg >= next_expected_reg)
            begin
                next_expected_reg <= rx_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        next_reg <= next_next;
        word_reg <= word_next;
        if (in_acc)
        begin
            act_reg     <= s_axis_tuser;
            rx_reg      <= s_axis_tdata[15:0];
            present_reg <= s_axis_tdata[16];
            stop_reg    <= {1'b0, s_axis_tdata[32:17]} + {1'b0, s_axis_tdata[48:33]};
            now_reg     <= s_axis_tdata[80:49];
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {7'd0, res_reg.overflow, res_reg.range_length,
                            res_reg.range_first, res_reg.seq_out};

`include "assert_macros.svh"
    `ASSERT_IMP(a_ffill_bound, clk, rst_n, 1'b1, ffill_reg <= 7'(FLIGHT_DEPTH))
    `ASSERT_IMP(a_pfill_bound, clk, rst_n, 1'b1, pfill_reg <= 7'(PENDING_DEPTH))
    `ASSERT_NXT(a_one_item, clk, rst_n, in_acc, state_reg == ST_WORK)
endmodule
